// ----- design/dna_transition_transversion_counter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the transition / transversion counter.
// Shared checking shorthand used at the end of the design modules.
// ----------------------------------------------------------------------------
`ifndef DNA_TRANSITION_TRANSVERSION_COUNTER_CORE_DEFINES_SVH
`define DNA_TRANSITION_TRANSVERSION_COUNTER_CORE_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define DTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define DTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dtc_pkg.sv -----
// ----------------------------------------------------------------------------
// dtc_pkg
// Types, constants and the 32-bit population count of the counter.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int WORD_W  = 64;
  localparam int BASES   = WORD_W / 2;
  localparam int CNT_W   = $clog2(BASES + 1);
  localparam int OUT_W   = 40;

  localparam logic [BASES-1:0] M1 = 32'h5555_5555;
  localparam logic [BASES-1:0] M2 = 32'h3333_3333;
  localparam logic [BASES-1:0] M4 = 32'h0F0F_0F0F;

  typedef struct packed {
    logic [CNT_W-1:0] ts;
    logic [CNT_W-1:0] tv;
    logic [CNT_W-1:0] res;
  } cnt_t;

  function automatic logic [CNT_W-1:0] popcount32(input logic [BASES-1:0] x);
    logic [BASES-1:0] v1;
    logic [BASES-1:0] v2;
    logic [BASES-1:0] v3;
    logic [BASES-1:0] v4;
    logic [BASES-1:0] v5;
    v1 = (x & M1) + ((x >> 1) & M1);
    v2 = (v1 & M2) + ((v1 >> 2) & M2);
    v3 = (v2 + (v2 >> 4)) & M4;
    v4 = v3 + (v3 >> 8);
    v5 = v4 + (v4 >> 16);
    return v5[CNT_W-1:0];
  endfunction

endpackage

// ----- design/dtc_classify.sv -----
// ----------------------------------------------------------------------------
// dtc_classify
// Classifies the 32 base positions of one word and counts each class.
// ----------------------------------------------------------------------------
module dtc_classify (
  input  logic [dtc_pkg::WORD_W-1:0] seq_a,
  input  logic [dtc_pkg::WORD_W-1:0] seq_b,
  input  logic [dtc_pkg::WORD_W-1:0] gap_a,
  input  logic [dtc_pkg::WORD_W-1:0] gap_b,
  output dtc_pkg::cnt_t              cnt
);

  logic [dtc_pkg::WORD_W-1:0] diff;
  logic [dtc_pkg::BASES-1:0]  valid;
  logic [dtc_pkg::BASES-1:0]  tv_hit;
  logic [dtc_pkg::BASES-1:0]  ts_hit;

  assign diff = seq_a ^ seq_b;

  always_comb begin
    for (int i = 0; i < dtc_pkg::BASES; i++) begin
      valid[i]  = gap_a[2*i] & gap_b[2*i];
      tv_hit[i] = diff[2*i+1] & valid[i];
      ts_hit[i] = diff[2*i] & ~diff[2*i+1] & valid[i];
    end
  end

  assign cnt.ts  = dtc_pkg::popcount32(ts_hit);
  assign cnt.tv  = dtc_pkg::popcount32(tv_hit);
  assign cnt.res = dtc_pkg::popcount32(valid);

endmodule

// ----- design/dtc_accum.sv -----
// ----------------------------------------------------------------------------
// dtc_accum
// Three saturating running totals that clear after the last word of a pair.
// ----------------------------------------------------------------------------
`include "dna_transition_transversion_counter_core_defines.svh"

module dtc_accum #(
  parameter int COUNT_WIDTH = 40
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   last,
  input  dtc_pkg::cnt_t          cnt,
  output logic [COUNT_WIDTH-1:0] ts_sum,
  output logic [COUNT_WIDTH-1:0] tv_sum,
  output logic [COUNT_WIDTH-1:0] res_sum
);

  localparam int CW = COUNT_WIDTH;
  localparam int CN = dtc_pkg::CNT_W;

  logic [CW-1:0] ts_total_r;
  logic [CW-1:0] tv_total_r;
  logic [CW-1:0] res_total_r;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] t,
                                            input logic [CN-1:0] inc);
    logic [CW:0] s;
    s = {1'b0, t} + {{(CW + 1 - CN){1'b0}}, inc};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  assign ts_sum  = sat_add(ts_total_r, cnt.ts);
  assign tv_sum  = sat_add(tv_total_r, cnt.tv);
  assign res_sum = sat_add(res_total_r, cnt.res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_total_r  <= '0;
      tv_total_r  <= '0;
      res_total_r <= '0;
    end else if (en) begin
      if (last) begin
        ts_total_r  <= '0;
        tv_total_r  <= '0;
        res_total_r <= '0;
      end else begin
        ts_total_r  <= ts_sum;
        tv_total_r  <= tv_sum;
        res_total_r <= res_sum;
      end
    end
  end

  `DTC_ASSERT_NEXT(a_clear_after_last, en && last,
    ts_total_r == '0 && tv_total_r == '0 && res_total_r == '0,
    "Totals not cleared after the last word.")
  `DTC_ASSERT_NEXT(a_res_no_wrap, en && !last, res_total_r >= $past(res_total_r),
    "Residue total decreased without a clear.")

endmodule

// ----- design/dna_transition_transversion_counter_core.sv -----
// ----------------------------------------------------------------------------
// dna_transition_transversion_counter_core
// Counts transitions, transversions and gap-free residues over two aligned
// DNA sequences streamed as 64-bit words of 32 two-bit bases, each with a
// gap-filter word whose field low bit marks a valid base. The block takes
// one word per cycle: a word is registered, then classified and counted
// from that register, and its counts go into three saturating totals of
// COUNT_WIDTH bits. On the word marked last the totals, that word
// included, are placed in the output register as one result word and the
// totals clear for the next pair. The rate of one word per cycle is set
// by the single counting stage and holds as long as a pending result is
// taken before the next last word reaches that stage.
// ----------------------------------------------------------------------------
`include "dna_transition_transversion_counter_core_defines.svh"

module dna_transition_transversion_counter_core #(
  parameter int COUNT_WIDTH = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dtc_pkg::WORD_W-1:0]        in_seq_a_word,
  input  logic [dtc_pkg::WORD_W-1:0]        in_seq_b_word,
  input  logic [dtc_pkg::WORD_W-1:0]        in_gap_a_word,
  input  logic [dtc_pkg::WORD_W-1:0]        in_gap_b_word,
  input  logic                              in_last_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dtc_pkg::OUT_W-1:0]         out_transitions,
  output logic [dtc_pkg::OUT_W-1:0]         out_transversions,
  output logic [dtc_pkg::OUT_W-1:0]         out_residues
);

  localparam int OW = dtc_pkg::OUT_W;

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic                       s1_last_r;
  logic [dtc_pkg::WORD_W-1:0] s1_seq_a_r;
  logic [dtc_pkg::WORD_W-1:0] s1_seq_b_r;
  logic [dtc_pkg::WORD_W-1:0] s1_gap_a_r;
  logic [dtc_pkg::WORD_W-1:0] s1_gap_b_r;
  logic                       s1_go;
  logic                       in_take;
  logic                       out_load;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [OW-1:0]              out_ts_r;
  logic [OW-1:0]              out_tv_r;
  logic [OW-1:0]              out_res_r;

  dtc_pkg::cnt_t              cnt;
  logic [COUNT_WIDTH-1:0]     ts_sum;
  logic [COUNT_WIDTH-1:0]     tv_sum;
  logic [COUNT_WIDTH-1:0]     res_sum;

  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;
  assign out_load = s1_go && s1_last_r;

  assign s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_last_r  <= in_last_word;
      s1_seq_a_r <= in_seq_a_word;
      s1_seq_b_r <= in_seq_b_word;
      s1_gap_a_r <= in_gap_a_word;
      s1_gap_b_r <= in_gap_b_word;
    end
  end

  dtc_classify u_classify (
    .seq_a (s1_seq_a_r),
    .seq_b (s1_seq_b_r),
    .gap_a (s1_gap_a_r),
    .gap_b (s1_gap_b_r),
    .cnt   (cnt)
  );

  dtc_accum #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_go),
    .last    (s1_last_r),
    .cnt     (cnt),
    .ts_sum  (ts_sum),
    .tv_sum  (tv_sum),
    .res_sum (res_sum)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ts_r  <= OW'(ts_sum);
      out_tv_r  <= OW'(tv_sum);
      out_res_r <= OW'(res_sum);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_transitions   = out_ts_r;
  assign out_transversions = out_tv_r;
  assign out_residues      = out_res_r;

  `DTC_ASSERT_NEXT(a_last_gives_result, out_load, out_valid_r,
    "Last word did not produce a result word.")
  `DTC_ASSERT_NOW(a_res_bound, s1_valid_r, cnt.res <= dtc_pkg::CNT_W'(dtc_pkg::BASES),
    "Residue count of one word exceeds the base count.")
  `DTC_ASSERT_NOW(a_mismatch_bound, s1_valid_r,
    ({1'b0, cnt.ts} + {1'b0, cnt.tv}) <= {1'b0, cnt.res},
    "Mismatch counts exceed the residue count.")

endmodule

// ----- tb/mismatch_tally_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mismatch_tally_checker
// Watches the word and result channels of the transition / transversion
// counter. It keeps its own saturating totals, builds the expected result
// for every accepted last word, and compares each accepted result word
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module mismatch_tally_checker #(
  parameter int COUNT_WIDTH = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [dtc_pkg::WORD_W-1:0]  in_seq_a_word,
  input  logic [dtc_pkg::WORD_W-1:0]  in_seq_b_word,
  input  logic [dtc_pkg::WORD_W-1:0]  in_gap_a_word,
  input  logic [dtc_pkg::WORD_W-1:0]  in_gap_b_word,
  input  logic                        in_last_word,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [dtc_pkg::OUT_W-1:0]   out_transitions,
  input  logic [dtc_pkg::OUT_W-1:0]   out_transversions,
  input  logic [dtc_pkg::OUT_W-1:0]   out_residues,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [dtc_pkg::OUT_W-1:0] transitions;
    logic [dtc_pkg::OUT_W-1:0] transversions;
    logic [dtc_pkg::OUT_W-1:0] residues;
  } tally_t;

  localparam logic [63:0] TOTAL_MAX = {64{1'b1}} >> (64 - COUNT_WIDTH);

  logic [63:0] transition_sum;
  logic [63:0] transversion_sum;
  logic [63:0] residue_sum;
  tally_t      expected_tallies[$];

  function automatic logic [63:0] saturating_add(input logic [63:0] total,
                                                 input logic [63:0] inc);
    if (inc > TOTAL_MAX - total) return TOTAL_MAX;
    return total + inc;
  endfunction

  function automatic void classify_word(input  logic [dtc_pkg::WORD_W-1:0] seq_a,
                                        input  logic [dtc_pkg::WORD_W-1:0] seq_b,
                                        input  logic [dtc_pkg::WORD_W-1:0] gap_a,
                                        input  logic [dtc_pkg::WORD_W-1:0] gap_b,
                                        output int                         ts,
                                        output int                         tv,
                                        output int                         res);
    logic [1:0] diff;
    ts  = 0;
    tv  = 0;
    res = 0;
    for (int i = 0; i < dtc_pkg::BASES; i++) begin
      diff = seq_a[2*i +: 2] ^ seq_b[2*i +: 2];
      if (gap_a[2*i] && gap_b[2*i]) begin
        res++;
        if (diff[1]) tv++;
        else if (diff[0]) ts++;
      end
    end
  endfunction

  always @(posedge clk) begin
    tally_t want;
    int     ts;
    int     tv;
    int     res;
    int     mism;
    mism = 0;
    if (!rst_n) begin
      transition_sum   = '0;
      transversion_sum = '0;
      residue_sum      = '0;
      expected_tallies.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tallies.size() == 0) begin
          $error("Result word accepted with no expected result waiting.");
          mism++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_transitions !== want.transitions) begin
            $error("transitions: expected %0d, got %0d", want.transitions, out_transitions);
            mism++;
          end
          if (out_transversions !== want.transversions) begin
            $error("transversions: expected %0d, got %0d", want.transversions,
                   out_transversions);
            mism++;
          end
          if (out_residues !== want.residues) begin
            $error("residues: expected %0d, got %0d", want.residues, out_residues);
            mism++;
          end
        end
      end
      if (in_valid && in_ready) begin
        classify_word(in_seq_a_word, in_seq_b_word, in_gap_a_word, in_gap_b_word,
                      ts, tv, res);
        transition_sum   = saturating_add(transition_sum, 64'(ts));
        transversion_sum = saturating_add(transversion_sum, 64'(tv));
        residue_sum      = saturating_add(residue_sum, 64'(res));
        if (in_last_word) begin
          expected_tallies.push_back({transition_sum[dtc_pkg::OUT_W-1:0],
                                      transversion_sum[dtc_pkg::OUT_W-1:0],
                                      residue_sum[dtc_pkg::OUT_W-1:0]});
          transition_sum   = '0;
          transversion_sum = '0;
          residue_sum      = '0;
        end
      end
      errors  <= errors + mism;
      pending <= expected_tallies.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sequence word pairs with gap filters into the transition /
// transversion counter under bursty input and a stalling result side, runs
// directed corner words and longer back-to-back pairs of full words, then
// random pairs, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          COUNT_WIDTH  = 16;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          RANDOM_WORDS = 400;
  localparam int          SAT_WORDS    = 24;
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};
  localparam logic [63:0] LOW_BITS     = 64'h5555_5555_5555_5555;
  localparam logic [63:0] HIGH_BITS    = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_HOLD} ready_mode_e;

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic [dtc_pkg::WORD_W-1:0] in_seq_a_word  = '0;
  logic [dtc_pkg::WORD_W-1:0] in_seq_b_word  = '0;
  logic [dtc_pkg::WORD_W-1:0] in_gap_a_word  = '0;
  logic [dtc_pkg::WORD_W-1:0] in_gap_b_word  = '0;
  logic                       in_last_word   = 1'b0;
  logic                       out_ready      = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic [dtc_pkg::OUT_W-1:0]  out_transitions;
  logic [dtc_pkg::OUT_W-1:0]  out_transversions;
  logic [dtc_pkg::OUT_W-1:0]  out_residues;

  int          failures;
  int          pending_results;
  int          burst_left  = 0;
  bit          bursty      = 1'b1;
  int          idle_cycles = 0;
  ready_mode_e ready_mode  = READY_ALWAYS;
  int          ready_left  = 0;

  dna_transition_transversion_counter_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_seq_a_word    (in_seq_a_word),
    .in_seq_b_word    (in_seq_b_word),
    .in_gap_a_word    (in_gap_a_word),
    .in_gap_b_word    (in_gap_b_word),
    .in_last_word     (in_last_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_transitions  (out_transitions),
    .out_transversions(out_transversions),
    .out_residues     (out_residues)
  );

  mismatch_tally_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) tally_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_seq_a_word    (in_seq_a_word),
    .in_seq_b_word    (in_seq_b_word),
    .in_gap_a_word    (in_gap_a_word),
    .in_gap_b_word    (in_gap_b_word),
    .in_last_word     (in_last_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_transitions  (out_transitions),
    .out_transversions(out_transversions),
    .out_residues     (out_residues),
    .errors           (failures),
    .pending          (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(4, 48);
    end
    ready_left--;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic [63:0] seq_a, input logic [63:0] seq_b,
                           input logic [63:0] gap_a, input logic [63:0] gap_b,
                           input logic last);
    int gap;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid      <= 1'b1;
    in_seq_a_word <= seq_a;
    in_seq_b_word <= seq_b;
    in_gap_a_word <= gap_a;
    in_gap_b_word <= gap_b;
    in_last_word  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic send_random_pair(input int words);
    logic [63:0] seq_a;
    logic [63:0] seq_b;
    logic [63:0] gap_a;
    logic [63:0] gap_b;
    for (int w = 0; w < words; w++) begin
      seq_a = rand64();
      case ($urandom_range(0, 3))
        0:       seq_b = seq_a;
        1:       seq_b = rand64();
        2:       seq_b = seq_a ^ (rand64() & rand64() & rand64());
        default: seq_b = seq_a ^ (rand64() & LOW_BITS);
      endcase
      case ($urandom_range(0, 3))
        0: begin
          gap_a = LOW_BITS;
          gap_b = LOW_BITS;
        end
        1: begin
          gap_a = rand64();
          gap_b = rand64();
        end
        2: begin
          gap_a = ALL_ONES;
          gap_b = LOW_BITS & ~(rand64() & rand64());
        end
        default: begin
          gap_a = rand64() | LOW_BITS;
          gap_b = rand64() | HIGH_BITS;
        end
      endcase
      send_word(seq_a, seq_b, gap_a, gap_b, w == words - 1);
    end
  endtask

  initial begin
    int words_sent;
    int pairs_sent;
    int len;
    words_sent = 0;
    pairs_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word('0, '0, '0, '0, 1'b1);
    send_word(ALL_ONES, '0, ALL_ONES, ALL_ONES, 1'b1);
    send_word(LOW_BITS, '0, LOW_BITS, LOW_BITS, 1'b1);
    send_word(HIGH_BITS, '0, LOW_BITS, ALL_ONES, 1'b1);
    send_word(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
    send_word(ALL_ONES, '0, HIGH_BITS, HIGH_BITS, 1'b1);
    send_word(HIGH_BITS, LOW_BITS, LOW_BITS, ALL_ONES, 1'b1);
    send_word(ALL_ONES, '0, LOW_BITS, '0, 1'b1);
    send_word(ALL_ONES, '0, '0, ALL_ONES, 1'b1);
    send_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
              64'h5555_0000_FFFF_AAAA, 64'h7777_5555_1111_5555, 1'b1);
    send_word(ALL_ONES, '0, ALL_ONES, ALL_ONES, 1'b0);
    send_word(LOW_BITS, HIGH_BITS, LOW_BITS, LOW_BITS, 1'b0);
    send_word('0, '0, '0, '0, 1'b0);
    send_word(64'hC3C3_C3C3_0F0F_0F0F, 64'h3C3C_3C3C_F0F0_F0F0,
              ALL_ONES, 64'hDDDD_DDDD_5555_5555, 1'b1);
    wait_results_drained();

    // Longer back-to-back pairs of full words; each is followed by a short
    // pair to show that the totals restart from zero.
    bursty = 1'b0;
    for (int w = 0; w < SAT_WORDS; w++)
      send_word(HIGH_BITS, '0, ALL_ONES, ALL_ONES, w == SAT_WORDS - 1);
    send_word(ALL_ONES, LOW_BITS, LOW_BITS, LOW_BITS, 1'b1);
    for (int w = 0; w < SAT_WORDS; w++)
      send_word(LOW_BITS, '0, LOW_BITS, LOW_BITS, w == SAT_WORDS - 1);
    send_word(LOW_BITS, ALL_ONES, ALL_ONES, LOW_BITS, 1'b1);
    bursty = 1'b1;
    wait_results_drained();

    while (words_sent < RANDOM_WORDS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      send_random_pair(len);
      words_sent += len;
      pairs_sent++;
      if (pairs_sent % 15 == 0) wait_results_drained();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
